/* design/sws_pkg.sv */
// Shared types and constants for the sliding-window sender slot block.
// No dependencies; every other file in this folder imports it.
package sws_pkg;

   // Field widths
   localparam int TYPE_W     = 2;
   localparam int LEN_W      = 24;
   localparam int SEQ_W      = 32;
   localparam int ACT_W      = 3;
   localparam int SLOT_W     = 6;
   localparam int FLEN_W     = 13;
   localparam int USED_W     = 12;
   localparam int CNT_W      = 7;
   localparam int WIN_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Frame header bytes added to every payload
   localparam int HDR_BYTES = 8;

   // Reset values of the control registers
   localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd3;
   localparam logic [SEQ_W-1:0] SEQ_RESET    = 32'd100001;

   // Request kinds
   localparam logic [TYPE_W-1:0] REQ_SEND    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ACK     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_TIMEOUT = 2'd2;

   // Result actions
   localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SENT      = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DROPPED   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RESENT    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FREED     = 3'd4;
   localparam logic [ACT_W-1:0] ACT_UNMATCHED = 3'd5;
   localparam logic [ACT_W-1:0] ACT_FULL      = 3'd6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SLOTS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SEQUENCE = 1'd1;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [LEN_W-1:0]  remaining_len;
      logic              deliver;
      logic [SEQ_W-1:0]  ack_seq;
   } sws_req_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [SLOT_W-1:0] slot;
      logic [SEQ_W-1:0]  frame_seq;
      logic [FLEN_W-1:0] frame_len;
      logic [USED_W-1:0] consumed;
      logic [CNT_W-1:0]  busy_count;
      logic              all_acked;
   } sws_rsp_type;

   typedef struct packed {
      logic                  write;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } sws_csr_type;

endpackage

/* design/sws_chan_if.sv */
// Valid/ready channel interfaces: request, response and register write.
// Depends on sws_pkg for field widths.
interface sws_req_if;
   import sws_pkg::*;
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [LEN_W-1:0]  remaining_len;
   logic              deliver;
   logic [SEQ_W-1:0]  ack_seq;
   modport source (output valid, req_type, remaining_len, deliver, ack_seq, input ready);
   modport sink   (input valid, req_type, remaining_len, deliver, ack_seq, output ready);
endinterface

interface sws_rsp_if;
   import sws_pkg::*;
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [SLOT_W-1:0] slot;
   logic [SEQ_W-1:0]  frame_seq;
   logic [FLEN_W-1:0] frame_len;
   logic [USED_W-1:0] consumed;
   logic [CNT_W-1:0]  busy_count;
   logic              all_acked;
   modport source (output valid, action, slot, frame_seq, frame_len, consumed, busy_count,
                   all_acked, input ready);
   modport sink   (input valid, action, slot, frame_seq, frame_len, consumed, busy_count,
                   all_acked, output ready);
endinterface

interface sws_csr_if;
   import sws_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/sws_slot_engine.sv */
// Slot table, sequence counter, window register and busy counter.
// Decides one transaction per step. Depends on sws_pkg.
module sws_slot_engine #(
   parameter int MAX_SLOTS = 8,
   parameter int MAX_FRAME = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  sws_pkg::sws_req_type req,
   input  sws_pkg::sws_csr_type csr,
   output logic                 sweep_busy,
   output sws_pkg::sws_rsp_type rsp
);
   import sws_pkg::*;

   localparam int IDX_W       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_IW      = $clog2(MAX_SLOTS + 1);
   localparam int PAYLOAD_MAX = MAX_FRAME - HDR_BYTES;

   logic [MAX_SLOTS-1:0] busy_ff, busy_in;
   logic [SEQ_W-1:0]     seq_ff [MAX_SLOTS];
   logic [SEQ_W-1:0]     seq_in [MAX_SLOTS];
   logic [FLEN_W-1:0]    len_ff [MAX_SLOTS];
   logic [FLEN_W-1:0]    len_in [MAX_SLOTS];
   logic [SEQ_W-1:0]     next_seq_ff, next_seq_in;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [CNT_IW-1:0]    count_ff, count_in;
   logic                 sweep_ff, sweep_in;
   logic [IDX_W-1:0]     cursor_ff, cursor_in;
   logic [CNT_IW-1:0]    acc_ff, acc_in;

   logic [WIN_W-1:0]     win_eff;
   logic [MAX_SLOTS-1:0] active, cand, pick;
   logic                 found;
   logic [IDX_W-1:0]     sel_idx;
   logic [SEQ_W-1:0]     sel_seq;
   logic [FLEN_W-1:0]    sel_len;
   logic [USED_W-1:0]    used;
   logic                 take, release_slot;
   logic [CNT_IW-1:0]    count_after;

   // window saturated to 1..MAX_SLOTS
   always_comb begin
      if (window_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (window_ff > WIN_W'(MAX_SLOTS)) begin
         win_eff = WIN_W'(MAX_SLOTS);
      end else begin
         win_eff = window_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         active[i] = WIN_W'(i) < win_eff;
      end
   end

   // candidate lanes for this request kind
   always_comb begin
      cand = '0;
      case (req.req_type)
         REQ_SEND: begin
            cand = active & ~busy_ff;
         end
         REQ_ACK: begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
               cand[i] = active[i] & busy_ff[i] & (seq_ff[i] == req.ack_seq);
            end
         end
         REQ_TIMEOUT: begin
            cand = active & busy_ff;
         end
         default: begin
            cand = '0;
         end
      endcase
   end

   assign pick  = cand & (~cand + MAX_SLOTS'(1));
   assign found = |cand;

   always_comb begin
      sel_idx = '0;
      sel_seq = '0;
      sel_len = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (pick[i]) begin
            sel_idx = sel_idx | IDX_W'(i);
         end
         sel_seq = sel_seq | (seq_ff[i] & {SEQ_W{pick[i]}});
         sel_len = sel_len | (len_ff[i] & {FLEN_W{pick[i]}});
      end
   end

   assign used = (req.remaining_len > LEN_W'(PAYLOAD_MAX)) ? USED_W'(PAYLOAD_MAX)
                                                          : req.remaining_len[USED_W-1:0];

   always_comb begin
      rsp          = '0;
      take         = 1'b0;
      release_slot = 1'b0;
      case (req.req_type)
         REQ_SEND: begin
            if (req.remaining_len != '0) begin
               if (found) begin
                  take          = 1'b1;
                  rsp.action    = req.deliver ? ACT_SENT : ACT_DROPPED;
                  rsp.slot      = SLOT_W'(sel_idx);
                  rsp.frame_seq = next_seq_ff;
                  rsp.frame_len = FLEN_W'(used) + FLEN_W'(HDR_BYTES);
                  rsp.consumed  = used;
               end else begin
                  rsp.action = ACT_FULL;
               end
            end
         end
         REQ_ACK: begin
            if (found) begin
               release_slot  = 1'b1;
               rsp.action    = ACT_FREED;
               rsp.slot      = SLOT_W'(sel_idx);
               rsp.frame_seq = sel_seq;
               rsp.frame_len = sel_len;
            end else begin
               rsp.action    = ACT_UNMATCHED;
               rsp.frame_seq = req.ack_seq;
            end
         end
         REQ_TIMEOUT: begin
            if (found) begin
               rsp.action    = ACT_RESENT;
               rsp.slot      = SLOT_W'(sel_idx);
               rsp.frame_seq = sel_seq;
               rsp.frame_len = sel_len;
            end
         end
         default: begin
            rsp.action = ACT_NONE;
         end
      endcase
      count_after    = count_ff + CNT_IW'(take) - CNT_IW'(release_slot);
      rsp.busy_count = CNT_W'(count_after);
      rsp.all_acked  = (count_after == '0);
   end

   // next state
   always_comb begin
      busy_in     = busy_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      next_seq_in = next_seq_ff;
      window_in   = window_ff;
      count_in    = count_ff;
      sweep_in    = sweep_ff;
      cursor_in   = cursor_ff;
      acc_in      = acc_ff;

      if (step) begin
         if (take) begin
            busy_in     = busy_ff | pick;
            next_seq_in = next_seq_ff + SEQ_W'(1);
            for (int i = 0; i < MAX_SLOTS; i++) begin
               if (pick[i]) begin
                  seq_in[i] = next_seq_ff;
                  len_in[i] = FLEN_W'(used) + FLEN_W'(HDR_BYTES);
               end
            end
         end
         if (release_slot) begin
            busy_in = busy_ff & ~pick;
         end
         count_in = count_after;
      end

      // recount of busy slots after a window change, one slot a cycle
      if (sweep_ff) begin
         acc_in    = acc_ff + CNT_IW'(busy_ff[cursor_ff] & active[cursor_ff]);
         cursor_in = cursor_ff + IDX_W'(1);
         if (cursor_ff == IDX_W'(MAX_SLOTS - 1)) begin
            count_in = acc_in;
            sweep_in = 1'b0;
         end
      end

      if (csr.write) begin
         case (csr.index)
            CSR_WINDOW_SLOTS: begin
               window_in = csr.data[WIN_W-1:0];
               sweep_in  = 1'b1;
               cursor_in = '0;
               acc_in    = '0;
            end
            CSR_FIRST_SEQUENCE: begin
               next_seq_in = csr.data[SEQ_W-1:0];
            end
            default: begin
               window_in = window_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= '0;
         next_seq_ff <= SEQ_RESET;
         window_ff   <= WINDOW_RESET;
         count_ff    <= '0;
         sweep_ff    <= 1'b0;
         cursor_ff   <= '0;
         acc_ff      <= '0;
      end else begin
         busy_ff     <= busy_in;
         next_seq_ff <= next_seq_in;
         window_ff   <= window_in;
         count_ff    <= count_in;
         sweep_ff    <= sweep_in;
         cursor_ff   <= cursor_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      len_ff <= len_in;
   end

   assign sweep_busy = sweep_ff;

endmodule

/* design/sliding_window_sender_slots.sv */
// Top level of the sliding-window sender slot block.
// Depends on sws_pkg, the channel interfaces in sws_chan_if and sws_slot_engine.
//
// Keeps the transmit slots of a sliding-window ARQ sender. Each request
// transaction (send, ack or timeout) gives exactly one response transaction
// carrying the action, slot, sequence number, frame length, payload bytes
// taken and the busy count after the request.
// Channels: req_chan in, rsp_chan out, csr_chan for register writes
// (index 0 window size, index 1 first sequence number). csr_chan is always ready.
// A request accepted into the input register is decided once the output register
// has room and no recount runs; its response is then registered in the output
// register. The decision is one pass of parallel compares over the slot registers
// plus a priority pick. Throughput: one transaction per cycle while rsp_chan stays
// ready and no recount runs. A write of the window size starts a recount of busy
// slots; requests wait in the input register during it.
// Reset: all slots free, window 3, next sequence 100001, channels empty.
// Receiver stall: the response is held in the output register and one
// further request is taken into the input register; then req_chan.ready drops.
module sliding_window_sender_slots #(
   parameter int MAX_SLOTS = 8,
   parameter int MAX_FRAME = 4096
) (
   input  logic      clock,
   input  logic      reset,
   sws_req_if.sink   req_chan,
   sws_rsp_if.source rsp_chan,
   sws_csr_if.sink   csr_chan
);
   import sws_pkg::*;

   logic        hold_valid_ff, hold_valid_in;
   sws_req_type hold_ff, hold_in;
   logic        out_valid_ff, out_valid_in;
   sws_rsp_type out_ff, out_in;

   sws_rsp_type engine_rsp;
   sws_csr_type csr_wr;
   logic        sweep_busy;
   logic        out_free;
   logic        step;
   logic        accept;

   // output register drains or is empty
   assign out_free = !out_valid_ff || rsp_chan.ready;
   // decide the held request when there is room for its response
   assign step     = hold_valid_ff && out_free && !sweep_busy;
   assign req_chan.ready = !hold_valid_ff || step;
   assign accept   = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;
   assign csr_wr.write   = csr_chan.valid;
   assign csr_wr.index   = csr_chan.index;
   assign csr_wr.data    = csr_chan.data;

   sws_slot_engine #(
      .MAX_SLOTS (MAX_SLOTS),
      .MAX_FRAME (MAX_FRAME)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .req        (hold_ff),
      .csr        (csr_wr),
      .sweep_busy (sweep_busy),
      .rsp        (engine_rsp)
   );

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (step) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in         = 1'b1;
         hold_in.req_type      = req_chan.req_type;
         hold_in.remaining_len = req_chan.remaining_len;
         hold_in.deliver       = req_chan.deliver;
         hold_in.ack_seq       = req_chan.ack_seq;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (step) begin
         out_valid_in = 1'b1;
         out_in       = engine_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.action     = out_ff.action;
   assign rsp_chan.slot       = out_ff.slot;
   assign rsp_chan.frame_seq  = out_ff.frame_seq;
   assign rsp_chan.frame_len  = out_ff.frame_len;
   assign rsp_chan.consumed   = out_ff.consumed;
   assign rsp_chan.busy_count = out_ff.busy_count;
   assign rsp_chan.all_acked  = out_ff.all_acked;

endmodule
